[hw/rtl/hci_pkg.sv]
// Shared types and constants for the hash chain insert block.
package hci_pkg;

  // Fixed field widths of the channels and the configuration register
  localparam int KIND_W   = 1;
  localparam int BUCKET_W = 11;
  localparam int OFFSET_W = 23;
  localparam int ADDR_W   = 12;
  localparam int RDWORD_W = 24;
  localparam int NFREE_W  = 12;
  localparam int CFG_W    = 11;

  // Default store geometry
  localparam int STORE_WORDS_DEF = 4096;
  localparam int WORD_BITS_DEF   = 24;

  // Bucket count after reset
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(1);

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_ALLOC0,
    ST_ALLOC1,
    ST_ALLOC2,
    ST_EMIT
  } hci_state_t;

endpackage

[hw/rtl/hci_in_if.sv]
// Input channel: insert or read request beats.
interface hci_in_if import hci_pkg::*; ();
  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [BUCKET_W-1:0] bucket;
  logic [OFFSET_W-1:0] record_offset;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, kind, bucket, record_offset, address, input ready);
  modport sink   (input valid, kind, bucket, record_offset, address, output ready);
endinterface

[hw/rtl/hci_out_if.sv]
// Result channel: one beat per accepted request.
interface hci_out_if import hci_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RDWORD_W-1:0] read_word;
  logic                pool_full;
  logic [NFREE_W-1:0]  next_free;

  modport source (output valid, read_word, pool_full, next_free, input ready);
  modport sink   (input valid, read_word, pool_full, next_free, output ready);
endinterface

[hw/rtl/hash_chain_insert.sv]
// Top level: chained hash table builder over one word store.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------
//  in_ch   | in  | valid / ready    | kind, bucket, record_offset, address
//  out_ch  | out | valid / ready    | read_word, pool_full, next_free
//  cfg     | in  | cfg_we           | cfg_wdata = bucket_count
//
//  One request at a time; the store has one read and one write port.
//  Read: IDLE, READ, EMIT. Insert: IDLE, WALK again per chain pointer
//  followed, ALLOC0 to ALLOC2 for a new node, then EMIT; a bad bucket or
//  address skips to EMIT. After reset a clearing pass writes the empty
//  marker to every word with in_ch.ready low; cfg writes are taken as ever.
//  A new request is taken while the previous result still waits in the
//  output register; a stalled output holds the block in its last state.
module hash_chain_insert import hci_pkg::*; #(
  parameter int STORE_WORDS = STORE_WORDS_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  hci_in_if.sink           in_ch,
  hci_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int CW = AW + 1;
  localparam int BW = ((CW > CFG_W) ? CW : CFG_W) + 1;
  localparam int PW = WORD_BITS - 1;

  localparam logic [WORD_BITS-1:0] EMPTY_MARK = '1;
  localparam logic [AW-1:0]        CLR_LAST   = AW'(STORE_WORDS - 1);
  localparam logic [31:0]          STORE_N    = 32'(STORE_WORDS);

  hci_state_t state_r, state_nxt;

  logic [CFG_W-1:0]     bc_r;
  logic [CW-1:0]        nc_r, nc_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic [AW-1:0]        base_r, base_nxt;
  logic [AW:0]          steps_r, steps_nxt;
  logic [PW-1:0]        off_r, off_nxt;
  logic [WORD_BITS-1:0] val_r, val_nxt;
  logic [RDWORD_W-1:0]  res_word_r, res_word_nxt;
  logic                 res_full_r, res_full_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [RDWORD_W-1:0]  out_word_r, out_word_nxt;
  logic                 out_full_r, out_full_nxt;
  logic [NFREE_W-1:0]   out_nf_r, out_nf_nxt;

  // memory port signals
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  // decoded request and datapath terms
  logic                         in_acc;
  logic                         addr_ok, bucket_ok;
  logic [ADDR_W+AW-1:0]         addr_ext;
  logic [BUCKET_W+AW-1:0]       bucket_ext;
  logic [OFFSET_W+WORD_BITS-1:0] off_ext;
  logic [WORD_BITS+RDWORD_W-1:0] rdw_ext;
  logic [31:0]                  ptr_next;
  logic                         walk_bad;
  logic [BW-1:0]                base_cur;
  logic                         pool_short;
  logic [WORD_BITS+AW-1:0]      base_ext;
  logic                         out_free;

  hci_ram #(
    .DEPTH (STORE_WORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // request decode
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign addr_ext   = {{AW{1'b0}}, in_ch.address};
  assign bucket_ext = {{AW{1'b0}}, in_ch.bucket};
  assign off_ext    = {{WORD_BITS{1'b0}}, in_ch.record_offset};
  assign addr_ok    = 32'(in_ch.address) < STORE_N;
  assign bucket_ok  = (in_ch.bucket < bc_r) && (32'(in_ch.bucket) < STORE_N);

  // chain walk terms on the word just read
  assign ptr_next   = 32'(rd_data[PW-1:0]) + 32'd1;
  assign walk_bad   = (32'(steps_r) >= STORE_N) || (ptr_next >= STORE_N);
  assign base_cur   = BW'(bc_r) + BW'(nc_r);
  assign pool_short = (32'(base_cur) + 32'd2) > STORE_N;
  assign base_ext   = {{WORD_BITS{1'b0}}, base_r};
  assign rdw_ext    = {{RDWORD_W{1'b0}}, rd_data};

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind == KIND_READ) begin
            state_nxt = addr_ok ? ST_READ : ST_EMIT;
          end else begin
            state_nxt = bucket_ok ? ST_WALK : ST_EMIT;
          end
        end
      end
      ST_READ: state_nxt = ST_EMIT;
      ST_WALK: begin
        if (rd_data == EMPTY_MARK) begin
          state_nxt = ST_EMIT;
        end else if (rd_data[PW]) begin
          if (walk_bad) state_nxt = ST_EMIT;
        end else begin
          state_nxt = pool_short ? ST_EMIT : ST_ALLOC0;
        end
      end
      ST_ALLOC0: state_nxt = ST_ALLOC1;
      ST_ALLOC1: state_nxt = ST_ALLOC2;
      ST_ALLOC2: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // memory controls and datapath updates
  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = slot_r;
    wr_data      = {1'b0, off_r};
    rd_en        = 1'b0;
    rd_addr      = slot_r;
    clr_nxt      = clr_r;
    nc_nxt       = nc_r;
    slot_nxt     = slot_r;
    base_nxt     = base_r;
    steps_nxt    = steps_r;
    off_nxt      = off_r;
    val_nxt      = val_r;
    res_word_nxt = res_word_r;
    res_full_nxt = res_full_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt = out_word_r;
    out_full_nxt = out_full_r;
    out_nf_nxt   = out_nf_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = EMPTY_MARK;
        clr_nxt = clr_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_word_nxt = '0;
          res_full_nxt = 1'b0;
          slot_nxt     = bucket_ext[AW-1:0];
          steps_nxt    = '0;
          off_nxt      = off_ext[PW-1:0];
          if (in_ch.kind == KIND_READ) begin
            rd_en   = addr_ok;
            rd_addr = addr_ext[AW-1:0];
          end else begin
            rd_en   = bucket_ok;
            rd_addr = bucket_ext[AW-1:0];
          end
        end
      end
      ST_READ: begin
        res_word_nxt = rdw_ext[RDWORD_W-1:0];
      end
      ST_WALK: begin
        if (rd_data == EMPTY_MARK) begin
          // free slot at end of chain takes the offset
          wr_en = 1'b1;
        end else if (rd_data[PW]) begin
          // follow pointer to the node's link word
          if (!walk_bad) begin
            rd_en     = 1'b1;
            rd_addr   = ptr_next[AW-1:0];
            slot_nxt  = ptr_next[AW-1:0];
            steps_nxt = steps_r + (AW+1)'(1);
          end
        end else if (pool_short) begin
          res_full_nxt = 1'b1;
        end else begin
          base_nxt = base_cur[AW-1:0];
          val_nxt  = rd_data;
        end
      end
      ST_ALLOC0: begin
        // node first word keeps the displaced value
        wr_en   = 1'b1;
        wr_addr = base_r;
        wr_data = val_r;
      end
      ST_ALLOC1: begin
        wr_en   = 1'b1;
        wr_addr = base_r + AW'(1);
      end
      ST_ALLOC2: begin
        // slot becomes a flagged pointer to the new node
        wr_en   = 1'b1;
        wr_data = {1'b1, base_ext[PW-1:0]};
        nc_nxt  = nc_r + CW'(2);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_word_r;
          out_full_nxt  = res_full_r;
          out_nf_nxt    = base_cur[NFREE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      nc_r        <= '0;
      bc_r        <= BUCKET_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nc_r        <= nc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) bc_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    base_r     <= base_nxt;
    steps_r    <= steps_nxt;
    off_r      <= off_nxt;
    val_r      <= val_nxt;
    res_word_r <= res_word_nxt;
    res_full_r <= res_full_nxt;
    out_word_r <= out_word_nxt;
    out_full_r <= out_full_nxt;
    out_nf_r   <= out_nf_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_word = out_word_r;
  assign out_ch.pool_full = out_full_r;
  assign out_ch.next_free = out_nf_r;

endmodule

[hw/rtl/hci_ram.sv]
// Single port write, single port read word store with registered read data.
module hci_ram import hci_pkg::*; #(
  parameter int DEPTH = STORE_WORDS_DEF,
  parameter int WIDTH = WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[verif/hash_chain_insert_tb.sv]
// Self-checking testbench for the chained hash table insert block.
`timescale 1ns / 100ps

module hash_chain_insert_tb;
  import hci_pkg::*;

  localparam int unsigned STORE_N    = STORE_WORDS_DEF;
  localparam int unsigned CHAIN_BIT  = WORD_BITS_DEF - 1;
  localparam int unsigned LOOP_BKT   = 2044;
  localparam int unsigned TAIL_CYC   = 8;
  localparam int unsigned LIMIT_CYC  = 2000000;
  localparam logic [WORD_BITS_DEF-1:0] EMPTY_WORD = '1;

  typedef enum logic [1:0] {
    INS_DONE,
    INS_FULL,
    INS_DROPPED
  } insert_status_t;

  typedef struct packed {
    kind_t               kind;
    logic [BUCKET_W-1:0] bucket;
    logic [OFFSET_W-1:0] record_offset;
    logic [ADDR_W-1:0]   address;
    bit                  hold_for_drain;
  } request_t;

  typedef struct packed {
    logic [RDWORD_W-1:0] read_word;
    logic                pool_full;
    logic [NFREE_W-1:0]  next_free;
  } table_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  hci_in_if  in_ch ();
  hci_out_if out_ch ();

  hash_chain_insert uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the word store, node cursor and bucket count
  logic [WORD_BITS_DEF-1:0] tbl_words [STORE_N];
  int unsigned              node_cur;
  logic [CFG_W-1:0]         n_buckets;

  request_t      pending_reqs[$];
  table_result_t expected_results[$];

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned idle_max;

  // Handshake bookkeeping shared between edges
  bit          in_beat_done;
  bit          out_beat_done;
  bit          send_busy;
  request_t    send_item;
  int unsigned send_gap;
  int unsigned recv_stall;

  always #5 clk = ~clk;

  // Chain walk and node allocation, mirrors the store update of one insert
  function automatic insert_status_t table_insert(input int unsigned head,
                                                  input logic [WORD_BITS_DEF-1:0] ofs);
    int unsigned              slot;
    int unsigned              link;
    int unsigned              steps;
    int unsigned              base;
    logic [WORD_BITS_DEF-1:0] cur;
    slot  = head;
    cur   = tbl_words[head];
    steps = 0;
    if (cur == EMPTY_WORD) begin
      tbl_words[slot] = ofs;
      return INS_DONE;
    end
    while (cur[CHAIN_BIT]) begin
      link = 32'(cur[CHAIN_BIT-1:0]);
      // runaway walk or pointer off the end of the store: drop the insert
      if (steps >= STORE_N || link + 1 >= STORE_N) return INS_DROPPED;
      steps++;
      slot = link + 1;
      cur  = tbl_words[slot];
      if (cur == EMPTY_WORD) begin
        tbl_words[slot] = ofs;
        return INS_DONE;
      end
    end
    base = n_buckets + node_cur;
    if (base + 2 > STORE_N) return INS_FULL;
    tbl_words[base]     = cur;
    tbl_words[base + 1] = ofs;
    tbl_words[slot]     = {1'b1, (CHAIN_BIT)'(base)};
    node_cur += 2;
    return INS_DONE;
  endfunction

  // Expected result beat for one accepted request
  function automatic table_result_t apply_request(input request_t r);
    table_result_t  res;
    insert_status_t st;
    res = '0;
    if (r.kind == KIND_READ) begin
      res.read_word = tbl_words[r.address];
    end else if (r.bucket < n_buckets) begin
      st = table_insert(32'(r.bucket), {1'b0, r.record_offset});
      res.pool_full = (st == INS_FULL);
    end
    res.next_free = NFREE_W'(n_buckets + node_cur);
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Input side: present queued requests after a random gap
  always @(negedge clk) begin : send_side
    if (rst_n) begin
      if (in_beat_done) begin
        in_beat_done = 1'b0;
        send_busy    = 1'b0;
      end
      if (!send_busy && pending_reqs.size() != 0 &&
          !(pending_reqs[0].hold_for_drain && expected_results.size() != 0)) begin
        send_item = pending_reqs.pop_front();
        send_gap  = $urandom_range(0, idle_max);
        send_busy = 1'b1;
      end
      if (send_busy && send_gap == 0) begin
        in_ch.valid         <= 1'b1;
        in_ch.kind          <= send_item.kind;
        in_ch.bucket        <= send_item.bucket;
        in_ch.record_offset <= send_item.record_offset;
        in_ch.address       <= send_item.address;
      end else begin
        if (send_busy) send_gap--;
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side: random stall before each beat
  always @(negedge clk) begin : recv_side
    if (rst_n) begin
      if (out_beat_done) begin
        out_beat_done = 1'b0;
        recv_stall    = $urandom_range(0, idle_max);
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Beat capture: predict on input beats, compare on result beats
  always @(posedge clk) begin : watch
    request_t      seen;
    table_result_t want;
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        seen.kind           = in_ch.kind;
        seen.bucket         = in_ch.bucket;
        seen.record_offset  = in_ch.record_offset;
        seen.address        = in_ch.address;
        seen.hold_for_drain = 1'b0;
        expected_results.push_back(apply_request(seen));
        in_beat_done = 1'b1;
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        out_beat_done = 1'b1;
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing outstanding, word %h",
                                  out_ch.read_word));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.read_word !== want.read_word)
            flag_mismatch($sformatf("read_word %h, want %h", out_ch.read_word,
                                    want.read_word));
          if (out_ch.pool_full !== want.pool_full)
            flag_mismatch($sformatf("pool_full %b, want %b", out_ch.pool_full,
                                    want.pool_full));
          if (out_ch.next_free !== want.next_free)
            flag_mismatch($sformatf("next_free %0d, want %0d", out_ch.next_free,
                                    want.next_free));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYC) begin
      $display("[%0t] watchdog expired, %0d results outstanding", $realtime,
               expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_insert(input int unsigned bkt, input logic [OFFSET_W-1:0] ofs);
    request_t r;
    r               = '0;
    r.kind          = KIND_INSERT;
    r.bucket        = BUCKET_W'(bkt);
    r.record_offset = ofs;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_read(input int unsigned addr, input bit drain = 1'b0);
    request_t r;
    r                = '0;
    r.kind           = KIND_READ;
    r.address        = ADDR_W'(addr);
    r.hold_for_drain = drain;
    pending_reqs.push_back(r);
  endtask

  // Random request: mostly valid buckets, reads biased towards live words
  function automatic request_t draw_request();
    request_t    r;
    int unsigned top;
    r.kind = ($urandom_range(0, 99) < 30) ? KIND_READ : KIND_INSERT;
    if ($urandom_range(0, 4) == 0)
      r.bucket = BUCKET_W'($urandom_range(0, 2047));
    else
      r.bucket = BUCKET_W'($urandom_range(0, n_buckets - 1));
    case ($urandom_range(0, 9))
      0:       r.record_offset = '0;
      1:       r.record_offset = '1;
      default: r.record_offset = OFFSET_W'($urandom);
    endcase
    top = n_buckets + node_cur + 3;
    if (top > STORE_N - 1) top = STORE_N - 1;
    if ($urandom_range(0, 1) == 0)
      r.address = ADDR_W'($urandom);
    else
      r.address = ADDR_W'($urandom_range(0, top));
    r.hold_for_drain = ($urandom_range(0, 39) == 0);
    return r;
  endfunction

  task automatic queue_random(input int unsigned count, input int unsigned gap);
    idle_max = gap;
    repeat (count) pending_reqs.push_back(draw_request());
  endtask

  // Block is idle once every request has gone in and every result come back
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || send_busy || expected_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYC) @(negedge clk);
  endtask

  task automatic set_bucket_count(input int unsigned v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_buckets = CFG_W'(v);
  endtask

  initial begin : stimulus
    int unsigned low_bc;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_INSERT;
    in_ch.bucket        = '0;
    in_ch.record_offset = '0;
    in_ch.address       = '0;
    out_ch.ready        = 1'b0;
    for (int i = 0; i < STORE_N; i++) tbl_words[i] = EMPTY_WORD;
    node_cur  = 0;
    n_buckets = BUCKET_COUNT_RST;
    idle_max  = 3;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single bucket: store extremes, head fill, node allocation, bad buckets
    set_bucket_count(1);
    queue_read(0);
    queue_read(STORE_N - 1);
    queue_insert(0, '0);
    queue_insert(0, '1);
    queue_insert(0, 23'h555555);
    queue_insert(2047, 23'h2AAAAA);
    queue_insert(1, 23'h000001);
    for (int a = 0; a < 6; a++) queue_read(a);
    queue_random(70, 3);
    wait_idle();

    // Two buckets, back to back with no idling
    set_bucket_count(2);
    queue_read(1, 1'b1);
    queue_random(50, 0);
    wait_idle();

    // Mid-range count: old node words become heads
    set_bucket_count($urandom_range(3, 300));
    queue_random(120, 3);
    wait_idle();

    // Widest table; then shrink it so the next node lands on a chain tail,
    // which leaves a slot pointing at its own node and a looping chain
    set_bucket_count(2047);
    queue_insert(2046, 23'h000002);
    queue_insert(LOOP_BKT, 23'h0ABCDE);
    queue_insert(LOOP_BKT, 23'h154321);
    wait_idle();
    low_bc = int'(tbl_words[LOOP_BKT][CHAIN_BIT-1:0]) - node_cur;
    set_bucket_count(low_bc);
    queue_insert(LOOP_BKT, 23'h3FFFFF);
    queue_insert(LOOP_BKT, 23'h400000);
    queue_read(tbl_words[LOOP_BKT][CHAIN_BIT-1:0] + 1);
    wait_idle();

    set_bucket_count(2047);
    queue_random(75, 3);
    wait_idle();
    queue_random(75, 0);
    wait_idle();

    // Long chains through a few busy buckets
    idle_max = 3;
    repeat (40) begin
      if ($urandom_range(0, 9) == 0)
        queue_read($urandom_range(0, STORE_N - 1));
      else
        queue_insert($urandom_range(0, 3), OFFSET_W'($urandom));
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/hci_pkg.sv
hw/rtl/hci_in_if.sv
hw/rtl/hci_out_if.sv
hw/rtl/hci_ram.sv
hw/rtl/hash_chain_insert.sv
verif/hash_chain_insert_tb.sv
